@@ hw/rtl/wldq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wldq_pkg: shared types for the weighted L1 distance query block
// Field widths, input kinds, controller states, datapath commands and the
// status bundle returned by the datapath.
// ----------------------------------------------------------------------------
package wldq_pkg;

  localparam int KIND_W = 2;
  localparam int POS_W  = 31;
  localparam int WGT_W  = 20;
  localparam int COST_W = 62;

  typedef enum logic [KIND_W-1:0] {
    KIND_ADD   = 2'd0,
    KIND_QUERY = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SORT_CHECK,
    ST_SORT_KEY,
    ST_SORT_STEP,
    ST_BUILD_READ,
    ST_BUILD_MUL,
    ST_BUILD_ACC,
    ST_SEARCH,
    ST_SEARCH_CMP,
    ST_PREF,
    ST_MUL,
    ST_OUT,
    ST_ZERO
  } state_e;

  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_ADD,
    CMD_CLEAR,
    CMD_Q_START,
    CMD_SORT_LOAD,
    CMD_SORT_KEY,
    CMD_SORT_SHIFT,
    CMD_SORT_PLACE,
    CMD_BUILD_INIT,
    CMD_BUILD_READ,
    CMD_BUILD_MUL,
    CMD_BUILD_ACC,
    CMD_Q_READ,
    CMD_Q_CMP,
    CMD_Q_TOT,
    CMD_Q_PREF,
    CMD_Q_MUL,
    CMD_Q_OUT,
    CMD_Q_ZERO
  } cmd_e;

  typedef struct packed {
    logic count_zero;
    logic full;
    logic sums_ready;
    logic sort_more;
    logic shift;
    logic build_last;
    logic search_more;
    logic slot_free;
  } status_t;

endpackage

@@ hw/rtl/wldq_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wldq_in_if: input channel
// Valid/ready channel carrying one command beat: add, query or clear.
// ----------------------------------------------------------------------------
interface wldq_in_if import wldq_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        kind;
  logic signed [POS_W-1:0]  point_position;
  logic [WGT_W-1:0]         point_weight;
  logic signed [POS_W-1:0]  query_point;

  modport source (output valid, kind, point_position, point_weight, query_point,
                  input ready);
  modport sink   (input valid, kind, point_position, point_weight, query_point,
                  output ready);
endinterface

@@ hw/rtl/wldq_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wldq_out_if: result channel
// Valid/ready channel carrying one cost beat per query.
// ----------------------------------------------------------------------------
interface wldq_out_if import wldq_pkg::*;;
  logic              valid;
  logic              ready;
  logic [COST_W-1:0] cost;

  modport source (output valid, cost, input ready);
  modport sink   (input valid, cost, output ready);
endinterface

@@ hw/rtl/wldq_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wldq_ctrl: sequencing state machine
// Accepts beats, and steps the datapath through the lazy insertion sort, the
// prefix-sum build and the binary search of each query.
// ----------------------------------------------------------------------------
module wldq_ctrl import wldq_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [KIND_W-1:0] in_kind_i,
  output logic              in_ready_o,
  input  status_t           status_i,
  output cmd_e              cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = CMD_NONE;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (in_kind_i)
            KIND_ADD:   cmd_o = CMD_ADD;
            KIND_CLEAR: cmd_o = CMD_CLEAR;
            KIND_QUERY: begin
              cmd_o = CMD_Q_START;
              if (status_i.count_zero) begin
                state_d = ST_ZERO;
              end else if (!status_i.sums_ready) begin
                state_d = ST_SORT_CHECK;
              end else begin
                state_d = ST_SEARCH;
              end
            end
            default: cmd_o = CMD_NONE;
          endcase
        end
      end
      ST_SORT_CHECK: begin
        if (status_i.sort_more) begin
          cmd_o   = CMD_SORT_LOAD;
          state_d = ST_SORT_KEY;
        end else begin
          cmd_o   = CMD_BUILD_INIT;
          state_d = ST_BUILD_READ;
        end
      end
      ST_SORT_KEY: begin
        cmd_o   = CMD_SORT_KEY;
        state_d = ST_SORT_STEP;
      end
      ST_SORT_STEP: begin
        if (status_i.shift) begin
          cmd_o = CMD_SORT_SHIFT;
        end else begin
          cmd_o   = CMD_SORT_PLACE;
          state_d = ST_SORT_CHECK;
        end
      end
      ST_BUILD_READ: begin
        cmd_o   = CMD_BUILD_READ;
        state_d = ST_BUILD_MUL;
      end
      ST_BUILD_MUL: begin
        cmd_o   = CMD_BUILD_MUL;
        state_d = ST_BUILD_ACC;
      end
      ST_BUILD_ACC: begin
        cmd_o   = CMD_BUILD_ACC;
        state_d = status_i.build_last ? ST_SEARCH : ST_BUILD_READ;
      end
      ST_SEARCH: begin
        if (status_i.search_more) begin
          cmd_o   = CMD_Q_READ;
          state_d = ST_SEARCH_CMP;
        end else begin
          cmd_o   = CMD_Q_TOT;
          state_d = ST_PREF;
        end
      end
      ST_SEARCH_CMP: begin
        cmd_o   = CMD_Q_CMP;
        state_d = ST_SEARCH;
      end
      ST_PREF: begin
        cmd_o   = CMD_Q_PREF;
        state_d = ST_MUL;
      end
      ST_MUL: begin
        cmd_o   = CMD_Q_MUL;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (status_i.slot_free) begin
          cmd_o   = CMD_Q_OUT;
          state_d = ST_IDLE;
        end
      end
      ST_ZERO: begin
        if (status_i.slot_free) begin
          cmd_o   = CMD_Q_ZERO;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

@@ hw/rtl/wldq_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wldq_dp: storage and arithmetic
// Point and prefix-sum memories, sort and search indices, the two multipliers
// and the result register.
// ----------------------------------------------------------------------------
module wldq_dp import wldq_pkg::*; #(
  parameter int MAX_POINTS = 1024
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cmd_e                    cmd_i,
  input  logic signed [POS_W-1:0] point_position_i,
  input  logic [WGT_W-1:0]        point_weight_i,
  input  logic signed [POS_W-1:0] query_point_i,
  input  logic                    out_ready_i,
  output logic                    out_valid_o,
  output logic [COST_W-1:0]       cost_o,
  output status_t                 status_o
);

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int WW = WGT_W + $clog2(MAX_POINTS);

  // Point store and prefix-sum store.
  logic signed [POS_W-1:0] pos_mem [MAX_POINTS];
  logic [WGT_W-1:0]        wgt_mem [MAX_POINTS];
  logic [WW-1:0]           wp_mem  [MAX_POINTS];
  logic [COST_W-1:0]       mp_mem  [MAX_POINTS];

  logic                    pw_re, pw_we, pf_re, pf_we;
  logic [AW-1:0]           pw_raddr, pw_waddr, pf_raddr, pf_waddr;
  logic signed [POS_W-1:0] pw_wpos;
  logic [WGT_W-1:0]        pw_wwgt;

  logic signed [POS_W-1:0] rd_pos_q, key_pos_q, q_q;
  logic [WGT_W-1:0]        rd_wgt_q, key_wgt_q;
  logic [WW-1:0]           rd_wp_q, ws_q, wt_q, ws_next, pref_wp;
  logic [COST_W-1:0]       rd_mp_q, ms_q, mt_q, ms_next, pref_mp;
  logic [COST_W-1:0]       bprod_q, mprod_q, off_q, cost_q;
  logic [CW-1:0]           count_q, i_q, lo_q, hi_q, mid, mid_q;
  logic [AW-1:0]           j_q;
  logic                    ready_q, out_valid_q, full;

  logic signed [POS_W+WGT_W:0]    bprod;
  logic signed [WW+1:0]           coef;
  logic signed [WW+POS_W+1:0]     mprod;

  assign full    = (count_q == CW'(MAX_POINTS));
  assign mid     = lo_q + ((hi_q - lo_q) >> 1);
  assign ws_next = ws_q + WW'(rd_wgt_q);
  assign ms_next = ms_q + bprod_q;
  assign bprod   = rd_pos_q * $signed({1'b0, rd_wgt_q});
  assign pref_wp = (lo_q == '0) ? '0 : rd_wp_q;
  assign pref_mp = (lo_q == '0) ? '0 : rd_mp_q;
  // Points left of the query add weight*(q-p), points right add weight*(p-q).
  assign coef    = $signed({1'b0, pref_wp, 1'b0}) - $signed({2'b00, wt_q});
  assign mprod   = coef * q_q;

  always_comb begin
    pw_re    = 1'b0;
    pw_we    = 1'b0;
    pf_re    = 1'b0;
    pf_we    = 1'b0;
    pw_raddr = i_q[AW-1:0];
    pw_waddr = j_q;
    pf_raddr = AW'(count_q - CW'(1));
    pf_waddr = i_q[AW-1:0];
    pw_wpos  = key_pos_q;
    pw_wwgt  = key_wgt_q;
    case (cmd_i)
      CMD_ADD: begin
        pw_we    = !full;
        pw_waddr = count_q[AW-1:0];
        pw_wpos  = point_position_i;
        pw_wwgt  = point_weight_i;
      end
      CMD_SORT_LOAD:  pw_re = 1'b1;
      CMD_SORT_KEY: begin
        pw_re    = 1'b1;
        pw_raddr = i_q[AW-1:0] - AW'(1);
      end
      CMD_SORT_SHIFT: begin
        pw_we    = 1'b1;
        pw_wpos  = rd_pos_q;
        pw_wwgt  = rd_wgt_q;
        pw_re    = 1'b1;
        pw_raddr = j_q - AW'(2);
      end
      CMD_SORT_PLACE: pw_we = 1'b1;
      CMD_BUILD_READ: pw_re = 1'b1;
      CMD_BUILD_ACC:  pf_we = 1'b1;
      CMD_Q_READ: begin
        pw_re    = 1'b1;
        pw_raddr = mid[AW-1:0];
      end
      CMD_Q_TOT:  pf_re = 1'b1;
      CMD_Q_PREF: begin
        pf_re    = 1'b1;
        pf_raddr = AW'(lo_q - CW'(1));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (pw_we) begin
      pos_mem[pw_waddr] <= pw_wpos;
      wgt_mem[pw_waddr] <= pw_wwgt;
    end
    if (pw_re) begin
      rd_pos_q <= pos_mem[pw_raddr];
      rd_wgt_q <= wgt_mem[pw_raddr];
    end
    if (pf_we) begin
      wp_mem[pf_waddr] <= ws_next;
      mp_mem[pf_waddr] <= ms_next;
    end
    if (pf_re) begin
      rd_wp_q <= wp_mem[pf_raddr];
      rd_mp_q <= mp_mem[pf_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i)
      CMD_Q_START: begin
        q_q  <= query_point_i;
        lo_q <= '0;
        hi_q <= count_q;
        i_q  <= CW'(1);
      end
      CMD_SORT_KEY: begin
        key_pos_q <= rd_pos_q;
        key_wgt_q <= rd_wgt_q;
        j_q       <= i_q[AW-1:0];
      end
      CMD_SORT_SHIFT: j_q <= j_q - AW'(1);
      CMD_SORT_PLACE: i_q <= i_q + CW'(1);
      CMD_BUILD_INIT: begin
        i_q  <= '0;
        ws_q <= '0;
        ms_q <= '0;
      end
      CMD_BUILD_MUL: bprod_q <= COST_W'(bprod);
      CMD_BUILD_ACC: begin
        ws_q <= ws_next;
        ms_q <= ms_next;
        i_q  <= i_q + CW'(1);
      end
      CMD_Q_READ: mid_q <= mid;
      CMD_Q_CMP: begin
        if (rd_pos_q <= q_q) begin
          lo_q <= mid_q + CW'(1);
        end else begin
          hi_q <= mid_q;
        end
      end
      CMD_Q_PREF: begin
        wt_q <= rd_wp_q;
        mt_q <= rd_mp_q;
      end
      CMD_Q_MUL: begin
        mprod_q <= mprod[COST_W-1:0];
        off_q   <= {pref_mp[COST_W-2:0], 1'b0} - mt_q;
      end
      CMD_Q_OUT:  cost_q <= mprod_q - off_q;
      CMD_Q_ZERO: cost_q <= '0;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      ready_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i == CMD_ADD && !full) begin
        count_q <= count_q + CW'(1);
        ready_q <= 1'b0;
      end else if (cmd_i == CMD_CLEAR) begin
        count_q <= '0;
        ready_q <= 1'b0;
      end else if (cmd_i == CMD_BUILD_ACC && status_o.build_last) begin
        ready_q <= 1'b1;
      end
      if (cmd_i == CMD_Q_OUT || cmd_i == CMD_Q_ZERO) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o          = out_valid_q;
  assign cost_o               = cost_q;
  assign status_o.count_zero  = (count_q == '0);
  assign status_o.full        = full;
  assign status_o.sums_ready  = ready_q;
  assign status_o.sort_more   = (i_q < count_q);
  assign status_o.shift       = (j_q != '0) && (rd_pos_q > key_pos_q);
  assign status_o.build_last  = (i_q == count_q - CW'(1));
  assign status_o.search_more = (lo_q < hi_q);
  assign status_o.slot_free   = !out_valid_q || out_ready_i;

endmodule

@@ hw/rtl/weighted_l1_distance_query.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weighted_l1_distance_query: weighted absolute distance sum over a point set
// Stores up to MAX_POINTS weighted points and answers, per query beat, the sum
// of weight times distance to the query position.
// ----------------------------------------------------------------------------
// Add and clear beats are applied as they are accepted; adds to a full store
// are dropped. A query on an empty store returns a zero cost. Otherwise a
// query runs a binary search, which needs one registered read of the position
// memory and one compare per halving. The first query after the set has
// changed first re-sorts the store in place by insertion sort, shifting one
// moved point per memory write, then builds the prefix sums with a read, a
// multiply and an accumulate step per point. The result register lets one
// cost beat wait while the next command beat is taken.
module weighted_l1_distance_query import wldq_pkg::*; #(
  parameter int MAX_POINTS = 1024
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  wldq_in_if.sink    in_i,
  wldq_out_if.source out_o
);

  cmd_e    cmd;
  status_t status;
  logic    in_ready;

  wldq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_kind_i  (in_i.kind),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  wldq_dp #(
    .MAX_POINTS (MAX_POINTS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .point_position_i (in_i.point_position),
    .point_weight_i   (in_i.point_weight),
    .query_point_i    (in_i.query_point),
    .out_ready_i      (out_o.ready),
    .out_valid_o      (out_o.valid),
    .cost_o           (out_o.cost),
    .status_o         (status)
  );

  assign in_i.ready = in_ready;

  // Prefix sums are only ever built over a non-empty store.
  a_ready_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(status.sums_ready && status.count_zero))
    else $error("prefix sums marked valid on an empty store");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_ready && in_i.kind == KIND_CLEAR)
    |=> (status.count_zero && !status.sums_ready))
    else $error("clear beat did not empty the store");

  a_add_stale: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_ready && in_i.kind == KIND_ADD && !status.full)
    |=> (!status.sums_ready && !status.count_zero))
    else $error("accepted point did not invalidate the prefix sums");

endmodule
